// File: hw/rtl/rqrp_pkg.sv
package rqrp_pkg;

    localparam int unsigned MODE_W   = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned PREFIX_W = 7;
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned OUT_W    = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_ENQ    = 2'd0,
        MODE_DEQ    = 2'd1,
        MODE_REV    = 2'd2,
        MODE_UNUSED = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_PREFIX = 2'd3
    } t_status;

endpackage

// File: hw/rtl/ring_queue_reverse_prefix_unit.sv
// Enqueue, rejected requests, unused modes and reversals of fewer than two items give
// their result in the cycle after the request; a dequeue passes through S_DEQ first.
// A reversal steps through S_RDA, S_RDB, S_WRA and S_WRB for each swap: each swap uses
// the single read port twice and the single write port twice. busy is high while a dequeue
// or a reversal is in progress. Reset (synchronous, active low) empties the queue; the
// ring store is not cleared. Results appear for one cycle with o_valid and the receiver
// cannot stall them; the next request can be taken in that same cycle, not while busy.
module ring_queue_reverse_prefix_unit #(
    parameter int unsigned DEPTH      = 128,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [rqrp_pkg::MODE_W-1:0]           i_mode,
    input  logic signed [rqrp_pkg::OUT_W-1:0]     i_value,
    input  logic [rqrp_pkg::PREFIX_W-1:0]         i_prefix_len,
    output logic                                  o_valid,
    output logic signed [rqrp_pkg::OUT_W-1:0]     o_data_out,
    output logic [rqrp_pkg::STATUS_W-1:0]         o_status,
    output logic [rqrp_pkg::COUNT_W-1:0]          o_item_count
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = (PW > rqrp_pkg::PREFIX_W) ? PW : rqrp_pkg::PREFIX_W;
    localparam int unsigned SW = rqrp_pkg::PREFIX_W - 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEQ,
        S_RDA,
        S_RDB,
        S_WRA,
        S_WRB
    } t_state;

    t_state                r_state;
    logic [PW-1:0]         r_head;
    logic [PW-1:0]         r_tail;
    logic [PW-1:0]         r_pa;
    logic [PW-1:0]         r_pb;
    logic [SW-1:0]         r_left;
    logic [DATA_WIDTH-1:0] r_va;
    logic [DATA_WIDTH-1:0] r_rdata;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic                  accept;
    logic [PW-1:0]         cnt;
    logic [PW-1:0]         head_inc;
    logic [PW-1:0]         tail_inc;
    logic [PW-1:0]         pa_inc;
    logic [PW-1:0]         pb_dec;
    logic [PW:0]           b_sum;
    logic [PW-1:0]         b_start;
    logic                  is_full;
    logic                  is_empty;
    logic                  prefix_bad;
    logic                  mem_we;
    logic [PW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [PW-1:0]         mem_raddr;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    always_comb begin
        if (r_tail >= r_head) begin
            cnt = r_tail - r_head;
        end else begin
            cnt = PW'((PW+1)'(r_tail) + (PW+1)'(DEPTH) - (PW+1)'(r_head));
        end
        head_inc   = (r_head == PW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
        tail_inc   = (r_tail == PW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
        pa_inc     = (r_pa == PW'(DEPTH - 1)) ? '0 : r_pa + 1'b1;
        pb_dec     = (r_pb == '0) ? PW'(DEPTH - 1) : r_pb - 1'b1;
        // The last index of the prefix, head + k - 1, stays below twice the depth.
        b_sum      = (PW+1)'(r_head) + (PW+1)'(i_prefix_len) - 1'b1;
        b_start    = (b_sum >= (PW+1)'(DEPTH)) ? PW'(b_sum - (PW+1)'(DEPTH)) : PW'(b_sum);
        is_full    = (cnt == PW'(DEPTH - 1));
        is_empty   = (cnt == '0);
        prefix_bad = (CW'(i_prefix_len) > CW'(cnt));
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_tail;
        mem_wdata = DATA_WIDTH'(i_value);
        unique case (r_state)
            S_IDLE: begin
                mem_we = accept && (rqrp_pkg::t_mode'(i_mode) == rqrp_pkg::MODE_ENQ)
                    && !is_full;
            end
            S_WRA: begin
                mem_we    = 1'b1;
                mem_waddr = r_pa;
                mem_wdata = r_rdata;
            end
            S_WRB: begin
                mem_we    = 1'b1;
                mem_waddr = r_pb;
                mem_wdata = r_va;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_RDA:   mem_raddr = r_pa;
            S_RDB:   mem_raddr = r_pb;
            default: mem_raddr = r_head;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_tail       <= '0;
            o_valid      <= 1'b0;
            o_data_out   <= '0;
            o_status     <= rqrp_pkg::ST_OK;
            o_item_count <= '0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        o_data_out   <= '0;
                        o_status     <= rqrp_pkg::ST_OK;
                        o_item_count <= rqrp_pkg::COUNT_W'(cnt);
                        unique case (rqrp_pkg::t_mode'(i_mode))
                            rqrp_pkg::MODE_ENQ: begin
                                o_valid <= 1'b1;
                                if (is_full) begin
                                    o_status <= rqrp_pkg::ST_FULL;
                                end else begin
                                    r_tail       <= tail_inc;
                                    o_item_count <= rqrp_pkg::COUNT_W'(cnt + 1'b1);
                                end
                            end
                            rqrp_pkg::MODE_DEQ: begin
                                if (is_empty) begin
                                    o_valid  <= 1'b1;
                                    o_status <= rqrp_pkg::ST_EMPTY;
                                end else begin
                                    // The head word is read at this edge.
                                    r_state      <= S_DEQ;
                                    r_head       <= head_inc;
                                    o_item_count <= rqrp_pkg::COUNT_W'(cnt - 1'b1);
                                end
                            end
                            rqrp_pkg::MODE_REV: begin
                                if (prefix_bad) begin
                                    o_valid  <= 1'b1;
                                    o_status <= rqrp_pkg::ST_PREFIX;
                                end else if (i_prefix_len < rqrp_pkg::PREFIX_W'(2)) begin
                                    o_valid <= 1'b1;
                                end else begin
                                    r_state <= S_RDA;
                                    r_pa    <= r_head;
                                    r_pb    <= b_start;
                                    r_left  <= i_prefix_len[rqrp_pkg::PREFIX_W-1:1];
                                end
                            end
                            default: begin
                                o_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_DEQ: begin
                    o_valid    <= 1'b1;
                    o_data_out <= rqrp_pkg::OUT_W'(signed'(r_rdata));
                    r_state    <= S_IDLE;
                end
                S_RDA: begin
                    r_state <= S_RDB;
                end
                S_RDB: begin
                    r_va    <= r_rdata;
                    r_state <= S_WRA;
                end
                S_WRA: begin
                    r_state <= S_WRB;
                end
                S_WRB: begin
                    if (r_left == SW'(1)) begin
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_left  <= r_left - 1'b1;
                        r_pa    <= pa_inc;
                        r_pb    <= pb_dec;
                        r_state <= S_RDA;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_enq_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_mode == rqrp_pkg::MODE_ENQ) |=> (o_valid && !busy))
        else $error("enqueue result not given one cycle after the request");

    a_deq_two_cycles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_mode == rqrp_pkg::MODE_DEQ && !is_empty) |=> (busy && !o_valid) ##1 o_valid)
        else $error("dequeue result not given two cycles after the request");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head < PW'(DEPTH - 1) || r_head == PW'(DEPTH - 1))
        && (r_tail < PW'(DEPTH - 1) || r_tail == PW'(DEPTH - 1)))
        else $error("queue pointer beyond the ring");

    a_swap_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDA || r_state == S_RDB || r_state == S_WRA || r_state == S_WRB)
        |-> (r_left != '0))
        else $error("swap step with no swaps left");

    a_ptrs_hold_in_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDA) |=> ($stable(r_head) && $stable(r_tail)))
        else $error("queue pointers moved during a reversal");

    a_no_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && r_state != S_DEQ && r_state != S_WRB) |=> !o_valid)
        else $error("result given in the middle of a request");
`endif

endmodule

// File: sim/tb_ring_queue_reverse_prefix_unit.sv
`timescale 1ns / 100ps

module tb_ring_queue_reverse_prefix_unit;

    localparam int DEPTH           = 128;
    localparam int RANDOM_REQUESTS = 1700;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 300;
    localparam int DIRECTED_ROWS   = 25;

    typedef struct packed {
        logic [rqrp_pkg::OUT_W-1:0]   data;
        rqrp_pkg::t_status            status;
        logic [rqrp_pkg::COUNT_W-1:0] count;
    } t_queue_result;

    typedef struct {
        rqrp_pkg::t_mode               mode;
        logic [rqrp_pkg::OUT_W-1:0]    value;
        logic [rqrp_pkg::PREFIX_W-1:0] prefix;
        bit                            typed;
        t_queue_result                 result;
    } t_directed_row;

    typedef enum logic [1:0] {
        PHASE_FILL,
        PHASE_DRAIN,
        PHASE_MIXED
    } t_phase;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 start;
    logic                                 busy;
    logic [rqrp_pkg::MODE_W-1:0]          i_mode;
    logic signed [rqrp_pkg::OUT_W-1:0]    i_value;
    logic [rqrp_pkg::PREFIX_W-1:0]        i_prefix_len;
    logic                                 o_valid;
    logic signed [rqrp_pkg::OUT_W-1:0]    o_data_out;
    logic [rqrp_pkg::STATUS_W-1:0]        o_status;
    logic [rqrp_pkg::COUNT_W-1:0]         o_item_count;

    // Shadow copy of the queue, updated when a request is accepted.
    logic [rqrp_pkg::OUT_W-1:0]   shadow_ring [DEPTH];
    logic [rqrp_pkg::COUNT_W-1:0] shadow_head;
    logic [rqrp_pkg::COUNT_W-1:0] shadow_tail;

    t_queue_result expected_results [$];
    t_directed_row directed_rows [DIRECTED_ROWS];
    int            mismatch_count;
    int            stall_cycles;

    ring_queue_reverse_prefix_unit #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (rqrp_pkg::OUT_W)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_value      (i_value),
        .i_prefix_len (i_prefix_len),
        .o_valid      (o_valid),
        .o_data_out   (o_data_out),
        .o_status     (o_status),
        .o_item_count (o_item_count)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    function automatic logic [rqrp_pkg::COUNT_W-1:0] shadow_count();
        return shadow_tail - shadow_head;
    endfunction

    function automatic t_queue_result queue_predict(input rqrp_pkg::t_mode mode,
            input logic [rqrp_pkg::OUT_W-1:0] value, input logic [rqrp_pkg::PREFIX_W-1:0] k);
        t_queue_result res;
        logic [rqrp_pkg::COUNT_W-1:0] lo;
        logic [rqrp_pkg::COUNT_W-1:0] hi;
        logic [rqrp_pkg::OUT_W-1:0] held;
        res.data   = '0;
        res.status = rqrp_pkg::ST_OK;
        case (mode)
            rqrp_pkg::MODE_ENQ: begin
                if (shadow_count() == DEPTH - 1) begin
                    res.status = rqrp_pkg::ST_FULL;
                end else begin
                    shadow_ring[shadow_tail] = value;
                    shadow_tail = shadow_tail + 1'b1;
                end
            end
            rqrp_pkg::MODE_DEQ: begin
                if (shadow_count() == 0) begin
                    res.status = rqrp_pkg::ST_EMPTY;
                end else begin
                    res.data = shadow_ring[shadow_head];
                    shadow_head = shadow_head + 1'b1;
                end
            end
            rqrp_pkg::MODE_REV: begin
                if (k > shadow_count()) begin
                    res.status = rqrp_pkg::ST_PREFIX;
                end else begin
                    // Pointer sums wrap at the ring size through 7-bit truncation.
                    for (int i = 0; i < k / 2; i++) begin
                        lo = shadow_head + rqrp_pkg::COUNT_W'(i);
                        hi = shadow_head + k - 1'b1 - rqrp_pkg::COUNT_W'(i);
                        held = shadow_ring[lo];
                        shadow_ring[lo] = shadow_ring[hi];
                        shadow_ring[hi] = held;
                    end
                end
            end
            default: begin
            end
        endcase
        res.count = shadow_count();
        return res;
    endfunction

    task automatic report_mismatch(input string field,
            input logic [rqrp_pkg::OUT_W-1:0] expected_val,
            input logic [rqrp_pkg::OUT_W-1:0] got_val);
        $display("mismatch in %s: expected %0h, got %0h at %0t", field, expected_val, got_val,
            $time);
        mismatch_count++;
    endtask

    task automatic send_request(input rqrp_pkg::t_mode mode,
            input logic [rqrp_pkg::OUT_W-1:0] value,
            input logic [rqrp_pkg::PREFIX_W-1:0] prefix, input bit typed,
            input t_queue_result typed_result);
        t_queue_result predicted;
        start        <= 1'b1;
        i_mode       <= mode;
        i_value      <= value;
        i_prefix_len <= prefix;
        do @(posedge i_clk); while (busy);
        predicted = queue_predict(mode, value, prefix);
        expected_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic idle_gap(input bit quiet);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        gap = 0;
        if (!quiet) begin
            if (r >= 90) begin
                gap = $urandom_range(8, 40);
            end else if (r >= 55) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [rqrp_pkg::OUT_W-1:0] random_word();
        if ($urandom_range(0, 99) < 15) begin
            case ($urandom_range(0, 3))
                0: return 32'h0000_0000;
                1: return 32'hFFFF_FFFF;
                2: return 32'h7FFF_FFFF;
                default: return 32'h8000_0000;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [rqrp_pkg::PREFIX_W-1:0] random_prefix();
        int n;
        int r;
        n = shadow_count();
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return rqrp_pkg::PREFIX_W'($urandom_range(0, n));
        end else if (r < 75) begin
            return rqrp_pkg::PREFIX_W'(n);
        end else if (r < 85) begin
            return rqrp_pkg::PREFIX_W'((n == DEPTH - 1) ? n : n + 1);
        end
        return rqrp_pkg::PREFIX_W'($urandom_range(0, 2**rqrp_pkg::PREFIX_W - 1));
    endfunction

    task automatic send_random(input t_phase phase, output bit counted);
        int enq_pct;
        int deq_pct;
        int rev_pct;
        int r;
        rqrp_pkg::t_mode mode;
        case (phase)
            PHASE_FILL: begin
                enq_pct = 82; deq_pct = 8;  rev_pct = 8;
            end
            PHASE_DRAIN: begin
                enq_pct = 12; deq_pct = 70; rev_pct = 16;
            end
            default: begin
                enq_pct = 40; deq_pct = 33; rev_pct = 24;
            end
        endcase
        r = $urandom_range(0, 99);
        if (r < enq_pct) begin
            mode = rqrp_pkg::MODE_ENQ;
        end else if (r < enq_pct + deq_pct) begin
            mode = rqrp_pkg::MODE_DEQ;
        end else if (r < enq_pct + deq_pct + rev_pct) begin
            mode = rqrp_pkg::MODE_REV;
        end else begin
            mode = rqrp_pkg::MODE_UNUSED;
        end
        // Fields that the operation ignores still carry random bits.
        send_request(mode, random_word(), random_prefix(), 1'b0, '0);
        counted = (mode != rqrp_pkg::MODE_UNUSED);
    endtask

    // Results cannot be held off, so each strobe is checked at the edge that ends it.
    always @(posedge i_clk) begin
        t_queue_result oldest;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", '0, o_data_out);
            end else begin
                oldest = expected_results.pop_front();
                if (o_data_out !== oldest.data) begin
                    report_mismatch("data_out", oldest.data, o_data_out);
                end
                if (o_status !== oldest.status) begin
                    report_mismatch("status", rqrp_pkg::OUT_W'(oldest.status),
                        rqrp_pkg::OUT_W'(o_status));
                end
                if (o_item_count !== oldest.count) begin
                    report_mismatch("item_count", rqrp_pkg::OUT_W'(oldest.count),
                        rqrp_pkg::OUT_W'(o_item_count));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        t_phase phase;
        int phase_left;
        int random_sent;
        bit quiet;
        bit counted;

        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_mode         = rqrp_pkg::MODE_ENQ;
        i_value        = '0;
        i_prefix_len   = '0;
        mismatch_count = 0;
        shadow_head    = '0;
        shadow_tail    = '0;

        // Typed rows hold results that follow directly from the queue contents.
        directed_rows[0]  = '{rqrp_pkg::MODE_DEQ, 32'h0000_0000, 7'd0, 1'b1,
            '{'0, rqrp_pkg::ST_EMPTY, 7'd0}};
        directed_rows[1]  = '{rqrp_pkg::MODE_REV, 32'h0000_0000, 7'd0, 1'b1,
            '{'0, rqrp_pkg::ST_OK, 7'd0}};
        directed_rows[2]  = '{rqrp_pkg::MODE_REV, 32'h0000_0000, 7'd1, 1'b1,
            '{'0, rqrp_pkg::ST_PREFIX, 7'd0}};
        directed_rows[3]  = '{rqrp_pkg::MODE_REV, 32'hFFFF_FFFF, 7'd127, 1'b1,
            '{'0, rqrp_pkg::ST_PREFIX, 7'd0}};
        directed_rows[4]  = '{rqrp_pkg::MODE_UNUSED, 32'hFFFF_FFFF, 7'd127, 1'b1,
            '{'0, rqrp_pkg::ST_OK, 7'd0}};
        directed_rows[5]  = '{rqrp_pkg::MODE_ENQ, 32'h7FFF_FFFF, 7'd0, 1'b1,
            '{'0, rqrp_pkg::ST_OK, 7'd1}};
        directed_rows[6]  = '{rqrp_pkg::MODE_ENQ, 32'h8000_0000, 7'd127, 1'b1,
            '{'0, rqrp_pkg::ST_OK, 7'd2}};
        directed_rows[7]  = '{rqrp_pkg::MODE_ENQ, 32'hFFFF_FFFF, 7'd0, 1'b1,
            '{'0, rqrp_pkg::ST_OK, 7'd3}};
        directed_rows[8]  = '{rqrp_pkg::MODE_ENQ, 32'h0000_0000, 7'd0, 1'b1,
            '{'0, rqrp_pkg::ST_OK, 7'd4}};
        directed_rows[9]  = '{rqrp_pkg::MODE_ENQ, 32'h5A5A_5A5A, 7'd0, 1'b1,
            '{'0, rqrp_pkg::ST_OK, 7'd5}};
        directed_rows[10] = '{rqrp_pkg::MODE_REV, 32'h0000_0000, 7'd6, 1'b1,
            '{'0, rqrp_pkg::ST_PREFIX, 7'd5}};
        directed_rows[11] = '{rqrp_pkg::MODE_REV, 32'hFFFF_FFFF, 7'd0, 1'b1,
            '{'0, rqrp_pkg::ST_OK, 7'd5}};
        directed_rows[12] = '{rqrp_pkg::MODE_REV, 32'h0000_0000, 7'd1, 1'b1,
            '{'0, rqrp_pkg::ST_OK, 7'd5}};
        directed_rows[13] = '{rqrp_pkg::MODE_REV, 32'h0000_0000, 7'd5, 1'b0, '0};
        directed_rows[14] = '{rqrp_pkg::MODE_UNUSED, 32'h1234_5678, 7'd3, 1'b1,
            '{'0, rqrp_pkg::ST_OK, 7'd5}};
        directed_rows[15] = '{rqrp_pkg::MODE_REV, 32'h0000_0000, 7'd2, 1'b0, '0};
        directed_rows[16] = '{rqrp_pkg::MODE_DEQ, 32'hFFFF_FFFF, 7'd127, 1'b0, '0};
        directed_rows[17] = '{rqrp_pkg::MODE_DEQ, 32'h0000_0000, 7'd0, 1'b0, '0};
        directed_rows[18] = '{rqrp_pkg::MODE_DEQ, 32'h0000_0000, 7'd0, 1'b0, '0};
        directed_rows[19] = '{rqrp_pkg::MODE_DEQ, 32'h0000_0000, 7'd0, 1'b0, '0};
        directed_rows[20] = '{rqrp_pkg::MODE_DEQ, 32'h0000_0000, 7'd0, 1'b0, '0};
        directed_rows[21] = '{rqrp_pkg::MODE_DEQ, 32'h0000_0000, 7'd0, 1'b1,
            '{'0, rqrp_pkg::ST_EMPTY, 7'd0}};
        directed_rows[22] = '{rqrp_pkg::MODE_ENQ, 32'hA5A5_A5A5, 7'd0, 1'b1,
            '{'0, rqrp_pkg::ST_OK, 7'd1}};
        directed_rows[23] = '{rqrp_pkg::MODE_REV, 32'h0000_0000, 7'd1, 1'b1,
            '{'0, rqrp_pkg::ST_OK, 7'd1}};
        directed_rows[24] = '{rqrp_pkg::MODE_DEQ, 32'h0000_0000, 7'd0, 1'b1,
            '{32'hA5A5_A5A5, rqrp_pkg::ST_OK, 7'd0}};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[row]) begin
            send_request(directed_rows[row].mode, directed_rows[row].value,
                directed_rows[row].prefix, directed_rows[row].typed, directed_rows[row].result);
            idle_gap(1'b0);
        end

        // The first phase fills the queue so that full requests and the longest
        // reversal are reached early.
        phase       = PHASE_FILL;
        phase_left  = 200;
        quiet       = 1'b0;
        random_sent = 0;
        while (random_sent < RANDOM_REQUESTS) begin
            if (phase_left == 0) begin
                phase      = t_phase'($urandom_range(0, 2));
                phase_left = $urandom_range(30, 150);
                quiet      = ($urandom_range(0, 3) == 0);
            end
            send_random(phase, counted);
            if (counted) begin
                random_sent++;
            end
            phase_left--;
            if (random_sent < RANDOM_REQUESTS) begin
                idle_gap(quiet);
            end
        end

        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
